@@ rtl/plrb_pkg.sv @@
// ----------------------------------------------------------------------------
// plrb_pkg: shared types and constants of the ping-pong log record buffer
// Word formats, action and status codes, and the record header byte layout.
// ----------------------------------------------------------------------------
package plrb_pkg;

  localparam int BufBytesDefault = 1024 * 8;
  localparam int HeaderBytes     = 13;
  localparam int MsgLenW         = 13;
  localparam int Banks           = 16;
  localparam int BankW           = 4;

  typedef enum logic [1:0] {
    ActStart   = 2'd0,
    ActPayload = 2'd1,
    ActDrain   = 2'd2,
    ActFlush   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StAccepted  = 3'd0,
    StDropped   = 3'd1,
    StStall     = 3'd2,
    StEmpty     = 3'd3,
    StDrainByte = 3'd4
  } status_e;

  typedef struct packed {
    action_e              action;
    logic [7:0]           tag;
    logic [63:0]          timestamp;
    logic [MsgLenW-1:0]   msg_len;
    logic [7:0]           data_byte;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  read_byte;
    logic        drain_last;
    logic [31:0] sequence_res;
    logic [31:0] lost_count;
  } out_word_t;

  // Header layout: sequence (LE), tag, timestamp (LE).
  function automatic logic [7:0] hdr_byte(logic [31:0] seq, logic [7:0] tag,
                                          logic [63:0] ts, logic [BankW-1:0] k);
    logic [7:0] b;
    case (k)
      4'd0:    b = seq[7:0];
      4'd1:    b = seq[15:8];
      4'd2:    b = seq[23:16];
      4'd3:    b = seq[31:24];
      4'd4:    b = tag;
      4'd5:    b = ts[7:0];
      4'd6:    b = ts[15:8];
      4'd7:    b = ts[23:16];
      4'd8:    b = ts[31:24];
      4'd9:    b = ts[39:32];
      4'd10:   b = ts[47:40];
      4'd11:   b = ts[55:48];
      4'd12:   b = ts[63:56];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/plrb_ram.sv @@
// ----------------------------------------------------------------------------
// plrb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plrb_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data while no new read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ping_pong_log_record_buffer.sv @@
// ----------------------------------------------------------------------------
// ping_pong_log_record_buffer: two-buffer log record capture and drain
//
//   channel  direction  handshake                     word
//   in       sink       in_valid_i / in_ready_o       plrb_pkg::in_word_t
//   out      source     out_valid_o / out_ready_i     plrb_pkg::out_word_t
//   cfg      sink       cfg_valid_i / cfg_ready_o     strict_mode bit
//
// The store is 16 byte-wide banks, so a 13-byte header is written at once
// across at most two bank rows.
// A result passes the bank read register, then the output register, after its
// word is accepted; one word per cycle is sustained while out_ready_i is high.
// Reset clears all control state; the banks need no clearing pass.
// With out_ready_i low one result waits in the read stage and in_ready_o falls.
// ----------------------------------------------------------------------------
module ping_pong_log_record_buffer #(
  parameter int BUF_BYTES = plrb_pkg::BufBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plrb_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output plrb_pkg::out_word_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  localparam int PosW     = $clog2(BUF_BYTES);
  localparam int LvlW     = $clog2(BUF_BYTES + 1);
  localparam int WordW    = PosW - plrb_pkg::BankW;
  localparam int RamAw    = WordW + 1;
  localparam int RamDepth = 2 ** RamAw;
  localparam int NeedW    = plrb_pkg::MsgLenW + 1;
  localparam int CmpW     = (LvlW > NeedW) ? LvlW : NeedW;
  localparam int Banks    = plrb_pkg::Banks;
  localparam int BankW    = plrb_pkg::BankW;

  // control state
  logic [LvlW-1:0]             fill_q [2];
  logic [LvlW-1:0]             fill_d [2];
  logic [1:0]                  full_q, full_d;
  logic                        act_q, act_d;
  logic                        dsel_q, dsel_d;
  logic [LvlW-1:0]             dptr_q, dptr_d;
  logic [31:0]                 rec_q, rec_d;
  logic [31:0]                 lost_q, lost_d;
  logic [plrb_pkg::MsgLenW-1:0] pleft_q, pleft_d;
  logic                        pacc_q, pacc_d;
  logic                        strict_q;

  // read stage and output register
  logic                        s1_valid_q;
  plrb_pkg::out_word_t         s1_res_q;
  logic [BankW-1:0]            s1_lane_q;
  logic                        s1_rd_q;
  logic                        out_valid_q;
  plrb_pkg::out_word_t         out_data_q;

  logic                        in_acc, s1_move;
  plrb_pkg::status_e           status;
  logic                        last;
  logic                        rd_en;
  logic [RamAw-1:0]            rd_addr;
  logic [BankW-1:0]            rd_lane;

  logic                        hdr_wr, pay_wr;
  logic                        hdr_buf;
  logic [PosW-1:0]             hdr_pos, pay_pos;
  logic [NeedW-1:0]            need;
  logic [LvlW-1:0]             room;
  logic                        oversize, do_switch, tgt, dbuf;
  logic [LvlW-1:0]             p;

  logic                        bank_we    [Banks];
  logic [RamAw-1:0]            bank_waddr [Banks];
  logic [7:0]                  bank_wdata [Banks];
  logic [7:0]                  bank_rdata [Banks];
  logic [BankW-1:0]            bank_off   [Banks];

  assign s1_move     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || s1_move;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign need      = {1'b0, in_data_i.msg_len} + NeedW'(plrb_pkg::HeaderBytes);
  assign room      = LvlW'(BUF_BYTES) - fill_q[act_q];
  assign oversize  = CmpW'(need) > CmpW'(BUF_BYTES);
  assign do_switch = CmpW'(room) < CmpW'(need);
  assign tgt       = do_switch ? ~act_q : act_q;
  assign dbuf      = dsel_q;

  always_comb begin
    fill_d   = fill_q;
    full_d   = full_q;
    act_d    = act_q;
    dsel_d   = dsel_q;
    dptr_d   = dptr_q;
    rec_d    = rec_q;
    lost_d   = lost_q;
    pleft_d  = pleft_q;
    pacc_d   = pacc_q;
    status   = plrb_pkg::StAccepted;
    last     = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    rd_lane  = '0;
    hdr_wr   = 1'b0;
    hdr_buf  = tgt;
    hdr_pos  = fill_q[tgt][PosW-1:0];
    pay_wr   = 1'b0;
    pay_pos  = fill_q[act_q][PosW-1:0];
    p        = dptr_q;
    if (dptr_q >= fill_q[dbuf]) begin
      p = fill_q[dbuf] - LvlW'(1);
    end

    if (in_acc) begin
      case (in_data_i.action)
        plrb_pkg::ActStart: begin
          if (oversize) begin
            rec_d   = rec_q + 32'd1;
            lost_d  = (lost_q == '1) ? lost_q : lost_q + 32'd1;
            pacc_d  = 1'b0;
            pleft_d = '0;
            status  = plrb_pkg::StDropped;
          end else if (full_q[tgt] && strict_q) begin
            status = plrb_pkg::StStall;
          end else begin
            if (do_switch) begin
              // retire the active buffer; it drains first if the other is not full
              if (!full_q[~act_q]) begin
                dsel_d = act_q;
              end
              full_d[act_q] = 1'b1;
              act_d         = tgt;
            end
            rec_d   = rec_q + 32'd1;
            pacc_d  = 1'b0;
            pleft_d = '0;
            if (full_q[tgt]) begin
              lost_d = (lost_q == '1) ? lost_q : lost_q + 32'd1;
              status = plrb_pkg::StDropped;
            end else begin
              hdr_wr      = 1'b1;
              fill_d[tgt] = fill_q[tgt] + LvlW'(plrb_pkg::HeaderBytes);
              pleft_d     = in_data_i.msg_len;
              pacc_d      = in_data_i.msg_len != '0;
            end
          end
        end
        plrb_pkg::ActPayload: begin
          if (!pacc_q || pleft_q == '0 || full_q[act_q] ||
              fill_q[act_q] >= LvlW'(BUF_BYTES)) begin
            status = plrb_pkg::StDropped;
          end else begin
            pay_wr        = 1'b1;
            fill_d[act_q] = fill_q[act_q] + LvlW'(1);
            pleft_d       = pleft_q - plrb_pkg::MsgLenW'(1);
            pacc_d        = pleft_q != plrb_pkg::MsgLenW'(1);
          end
        end
        plrb_pkg::ActDrain: begin
          if (!full_q[dbuf] || fill_q[dbuf] == '0) begin
            status = plrb_pkg::StEmpty;
          end else begin
            status  = plrb_pkg::StDrainByte;
            rd_en   = 1'b1;
            rd_addr = {dbuf, p[PosW-1:BankW]};
            rd_lane = p[BankW-1:0];
            if (p + LvlW'(1) >= fill_q[dbuf]) begin
              // release the buffer after its last byte
              last         = 1'b1;
              full_d[dbuf] = 1'b0;
              fill_d[dbuf] = '0;
              dptr_d       = '0;
              dsel_d       = ~dbuf;
            end else begin
              dptr_d = p + LvlW'(1);
            end
          end
        end
        plrb_pkg::ActFlush: begin
          pacc_d  = 1'b0;
          pleft_d = '0;
          if (!full_q[act_q] && fill_q[act_q] != '0) begin
            if (!full_q[~act_q]) begin
              dsel_d = act_q;
            end
            full_d[act_q] = 1'b1;
          end
        end
        default: begin
          status = plrb_pkg::StAccepted;
        end
      endcase
    end
  end

  // Bank write steering: a header spreads over up to two rows, a payload byte
  // hits the one bank at its fill position.
  always_comb begin
    for (int b = 0; b < Banks; b++) begin
      bank_off[b]   = BankW'(b) - hdr_pos[BankW-1:0];
      bank_we[b]    = 1'b0;
      bank_waddr[b] = {act_q, pay_pos[PosW-1:BankW]};
      bank_wdata[b] = in_data_i.data_byte;
      if (hdr_wr) begin
        bank_we[b]    = bank_off[b] < BankW'(plrb_pkg::HeaderBytes);
        bank_waddr[b] = {hdr_buf, hdr_pos[PosW-1:BankW] +
                         WordW'(BankW'(b) < hdr_pos[BankW-1:0])};
        bank_wdata[b] = plrb_pkg::hdr_byte(rec_d, in_data_i.tag,
                                           in_data_i.timestamp, bank_off[b]);
      end else if (pay_wr) begin
        bank_we[b] = pay_pos[BankW-1:0] == BankW'(b);
      end
    end
  end

  for (genvar g = 0; g < Banks; g++) begin : g_bank
    plrb_ram #(
      .Width (8),
      .Depth (RamDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .waddr_i (bank_waddr[g]),
      .wdata_i (bank_wdata[g]),
      .re_i    (rd_en),
      .raddr_i (rd_addr),
      .rdata_o (bank_rdata[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q[0]   <= '0;
      fill_q[1]   <= '0;
      full_q      <= '0;
      act_q       <= 1'b0;
      dsel_q      <= 1'b0;
      dptr_q      <= '0;
      rec_q       <= '0;
      lost_q      <= '0;
      pleft_q     <= '0;
      pacc_q      <= 1'b0;
      strict_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      full_q  <= full_d;
      act_q   <= act_d;
      dsel_q  <= dsel_d;
      dptr_q  <= dptr_d;
      rec_q   <= rec_d;
      lost_q  <= lost_d;
      pleft_q <= pleft_d;
      pacc_q  <= pacc_d;
      if (cfg_valid_i) begin
        strict_q <= cfg_data_i;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q.status       <= status;
      s1_res_q.read_byte    <= 8'h00;
      s1_res_q.drain_last   <= last;
      s1_res_q.sequence_res <= rec_d;
      s1_res_q.lost_count   <= lost_d;
      s1_lane_q             <= rd_lane;
      s1_rd_q               <= rd_en;
    end
    if (s1_valid_q && s1_move) begin
      out_data_q.status       <= s1_res_q.status;
      out_data_q.read_byte    <= s1_rd_q ? bank_rdata[s1_lane_q] : 8'h00;
      out_data_q.drain_last   <= s1_res_q.drain_last;
      out_data_q.sequence_res <= s1_res_q.sequence_res;
      out_data_q.lost_count   <= s1_res_q.lost_count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // While any buffer is full, the drain select points at a full one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q[0] || full_q[1]) |-> full_q[dsel_q])
    else $error("drain select points at a buffer that is not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pacc_q |-> (pleft_q != '0))
    else $error("payload open with no bytes left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q[0] <= LvlW'(BUF_BYTES)) && (fill_q[1] <= LvlW'(BUF_BYTES)))
    else $error("fill level beyond buffer size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> (lost_q == $past(lost_q)) && (rec_q == $past(rec_q)))
    else $error("counters moved without an accepted word");

endmodule
